@@ hw/rtl/ipv6p_pkg.sv @@
// Shared types, character constants and helper functions for the IPv6 text parser.
// No dependencies; every other file in hw/rtl imports this package.
package ipv6p_pkg;

    localparam int unsigned GROUPS = 8;

    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;

    // Returned by hex_val for a character that is not a hex digit.
    localparam logic [4:0] HEX_NONE = 5'd16;

    typedef enum logic [2:0] {
        PH_LEAD          = 3'd0,
        PH_PLAIN         = 3'd1,
        PH_BRACKET       = 3'd2,
        PH_PLAIN_COLON   = 3'd3,
        PH_BRACKET_COLON = 3'd4,
        PH_DONE          = 3'd5
    } prs_phase_t;

    typedef struct packed {
        logic [7:0] text_char;
        logic       last_char;
    } in_item_t;

    typedef struct packed {
        logic        addr_ok;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
    } out_item_t;

    // Everything the gap expansion needs about one finished text.
    typedef struct packed {
        logic         ok;
        logic [127:0] groups;    // group 0 in bits 127:112
        logic [3:0]   n_groups;
        logic [3:0]   gap_pos;
        logic         gap_seen;
    } fin_t;

    function automatic logic is_blank(logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic [4:0] hex_val(logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
            d = c - CH_ZERO;
            return d[4:0];
        end
        if ((c >= CH_LOW_A) && (c <= CH_LOW_F)) begin
            d = c - CH_LOW_A + 8'd10;
            return d[4:0];
        end
        if ((c >= CH_UP_A) && (c <= CH_UP_F)) begin
            d = c - CH_UP_A + 8'd10;
            return d[4:0];
        end
        return HEX_NONE;
    endfunction

endpackage

@@ hw/rtl/ipv6p_parse_core.sv @@
// Per-character parse state machine and group store of the IPv6 text parser.
// Depends on ipv6p_pkg; feeds one fin_t per finished text to ipv6p_gap_expand.
module ipv6p_parse_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  ipv6p_pkg::in_item_t in_item,
    output logic                in_take,
    output logic                fin_valid,
    input  logic                fin_ready,
    output ipv6p_pkg::fin_t     fin_data
);
    import ipv6p_pkg::*;

    typedef struct packed {
        logic [15:0] dacc;
        logic [2:0]  dcnt;
        logic [3:0]  gcnt;
        logic [3:0]  gpos;
        logic        gseen;
        prs_phase_t  phase;
        logic        err;
        logic        we;
        logic [2:0]  waddr;
        logic [15:0] wdata;
    } step_t;

    logic [15:0] dacc_reg, dacc_next;
    logic [2:0]  dcnt_reg, dcnt_next;
    logic [3:0]  gcnt_reg, gcnt_next;
    logic [3:0]  gpos_reg, gpos_next;
    logic        gseen_reg, gseen_next;
    prs_phase_t  phase_reg, phase_next;
    logic        err_reg, err_next;
    logic [15:0] store_reg [GROUPS];
    step_t       st;
    logic        process;

    function automatic step_t finish_group(step_t s);
        step_t r;
        r = s;
        if (s.gcnt >= 4'(GROUPS)) begin
            r.err = 1'b1;
        end else begin
            r.we    = 1'b1;
            r.waddr = s.gcnt[2:0];
            r.wdata = s.dacc;
            r.gcnt  = s.gcnt + 4'd1;
        end
        r.dacc = '0;
        r.dcnt = '0;
        return r;
    endfunction

    function automatic step_t close_body(step_t s);
        step_t r;
        r = s;
        if (r.dcnt != 3'd0) begin
            r = finish_group(r);
        end
        if (!r.err) begin
            if (r.gseen) begin
                if (r.gcnt >= 4'(GROUPS)) begin
                    r.err = 1'b1;
                end
            end else if (r.gcnt != 4'(GROUPS)) begin
                r.err = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic step_t body_char(step_t s, logic [7:0] c, logic bracket);
        step_t      r;
        logic [4:0] v;
        r = s;
        v = hex_val(c);
        if (c == CH_RBRACK) begin
            if (bracket) begin
                r = close_body(r);
                r.phase = PH_DONE;
            end else begin
                r.err = 1'b1;
            end
        end else if (is_blank(c)) begin
            if (bracket) begin
                r.err = 1'b1;
            end else begin
                r = close_body(r);
                r.phase = PH_DONE;
            end
        end else if (c == CH_COLON) begin
            if ((r.gcnt == 4'd0) && !r.gseen && (r.dcnt == 3'd0)) begin
                r.phase = bracket ? PH_BRACKET_COLON : PH_PLAIN_COLON;
            end else if (r.dcnt != 3'd0) begin
                r = finish_group(r);
            end else if ((r.gcnt >= 4'(GROUPS)) || r.gseen) begin
                r.err = 1'b1;
            end else begin
                r.gseen = 1'b1;
                r.gpos  = r.gcnt;
            end
        end else begin
            if ((v == HEX_NONE) || (r.gcnt >= 4'(GROUPS)) || (r.dcnt >= 3'd4)) begin
                r.err = 1'b1;
            end else begin
                r.dacc = {r.dacc[11:0], v[3:0]};
                r.dcnt = r.dcnt + 3'd1;
            end
        end
        return r;
    endfunction

    // A character without the last mark never waits; the last one needs room downstream.
    assign process   = in_valid && (!in_item.last_char || fin_ready);
    assign in_take   = process;
    assign fin_valid = in_valid && in_item.last_char && fin_ready;

    always_comb begin
        st.dacc  = dacc_reg;
        st.dcnt  = dcnt_reg;
        st.gcnt  = gcnt_reg;
        st.gpos  = gpos_reg;
        st.gseen = gseen_reg;
        st.phase = phase_reg;
        st.err   = err_reg;
        st.we    = 1'b0;
        st.waddr = '0;
        st.wdata = '0;
        if (!st.err) begin
            unique case (st.phase)
                PH_LEAD: begin
                    if (is_blank(in_item.text_char)) begin
                        st.phase = PH_LEAD;
                    end else if (in_item.text_char == CH_LBRACK) begin
                        st.phase = PH_BRACKET;
                    end else begin
                        st.phase = PH_PLAIN;
                        st = body_char(st, in_item.text_char, 1'b0);
                    end
                end
                PH_PLAIN:   st = body_char(st, in_item.text_char, 1'b0);
                PH_BRACKET: st = body_char(st, in_item.text_char, 1'b1);
                PH_PLAIN_COLON, PH_BRACKET_COLON: begin
                    if (in_item.text_char == CH_COLON) begin
                        st.gseen = 1'b1;
                        st.gpos  = 4'd0;
                        st.phase = (st.phase == PH_PLAIN_COLON) ? PH_PLAIN : PH_BRACKET;
                    end else begin
                        st.err = 1'b1;
                    end
                end
                PH_DONE: begin
                    if (!is_blank(in_item.text_char)) begin
                        st.err = 1'b1;
                    end
                end
                default: st.err = 1'b1;
            endcase
        end
        if (in_item.last_char && !st.err) begin
            if (st.phase == PH_PLAIN) begin
                st = close_body(st);
            end else if (st.phase != PH_DONE) begin
                st.err = 1'b1;
            end
        end
    end

    // Snapshot of the groups including this cycle's write, so the next text can reuse the store.
    always_comb begin
        fin_data.ok       = !st.err;
        fin_data.n_groups = st.gcnt;
        fin_data.gap_pos  = st.gpos;
        fin_data.gap_seen = st.gseen;
        for (int k = 0; k < GROUPS; k++) begin
            fin_data.groups[127 - 16 * k -: 16] =
                (st.we && (st.waddr == 3'(k))) ? st.wdata : store_reg[k];
        end
    end

    always_comb begin
        dacc_next  = dacc_reg;
        dcnt_next  = dcnt_reg;
        gcnt_next  = gcnt_reg;
        gpos_next  = gpos_reg;
        gseen_next = gseen_reg;
        phase_next = phase_reg;
        err_next   = err_reg;
        if (process) begin
            if (in_item.last_char) begin
                dacc_next  = '0;
                dcnt_next  = '0;
                gcnt_next  = '0;
                gpos_next  = '0;
                gseen_next = 1'b0;
                phase_next = PH_LEAD;
                err_next   = 1'b0;
            end else begin
                dacc_next  = st.dacc;
                dcnt_next  = st.dcnt;
                gcnt_next  = st.gcnt;
                gpos_next  = st.gpos;
                gseen_next = st.gseen;
                phase_next = st.phase;
                err_next   = st.err;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dacc_reg  <= '0;
            dcnt_reg  <= '0;
            gcnt_reg  <= '0;
            gpos_reg  <= '0;
            gseen_reg <= 1'b0;
            phase_reg <= PH_LEAD;
            err_reg   <= 1'b0;
        end else begin
            dacc_reg  <= dacc_next;
            dcnt_reg  <= dcnt_next;
            gcnt_reg  <= gcnt_next;
            gpos_reg  <= gpos_next;
            gseen_reg <= gseen_next;
            phase_reg <= phase_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (process && st.we) begin
            store_reg[st.waddr] <= st.wdata;
        end
    end

endmodule

@@ hw/rtl/ipv6p_gap_expand.sv @@
// Finished-text register, "::" gap expansion and result register of the IPv6 text parser.
// Depends on ipv6p_pkg; takes fin_t from ipv6p_parse_core.
module ipv6p_gap_expand (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 fin_valid,
    output logic                 fin_ready,
    input  ipv6p_pkg::fin_t      fin_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ipv6p_pkg::out_item_t m_item
);
    import ipv6p_pkg::*;

    logic         fin_valid_reg, fin_valid_next;
    fin_t         fin_reg;
    logic         out_valid_reg, out_valid_next;
    out_item_t    out_reg;
    logic         fin_move;
    logic [127:0] head_mask;
    logic [127:0] tail_mask;
    logic [3:0]   shift_groups;
    logic [127:0] expanded;

    assign fin_move  = fin_valid_reg && (!out_valid_reg || m_ready);
    assign fin_ready = !fin_valid_reg || fin_move;

    // Groups before the gap stay put; groups after it slide to the end of the address.
    always_comb begin
        for (int k = 0; k < GROUPS; k++) begin
            head_mask[127 - 16 * k -: 16] = {16{4'(k) < fin_reg.gap_pos}};
            tail_mask[127 - 16 * k -: 16] =
                {16{(4'(k) >= fin_reg.gap_pos) && (4'(k) < fin_reg.n_groups)}};
        end
        shift_groups = 4'(GROUPS) - fin_reg.n_groups;
        if (!fin_reg.ok) begin
            expanded = '0;
        end else if (fin_reg.gap_seen) begin
            expanded = (fin_reg.groups & head_mask)
                     | ((fin_reg.groups & tail_mask) >> {shift_groups, 4'b0000});
        end else begin
            expanded = fin_reg.groups;
        end
    end

    always_comb begin
        fin_valid_next = fin_valid_reg;
        out_valid_next = out_valid_reg;
        if (fin_ready) begin
            fin_valid_next = fin_valid;
        end
        if (fin_move) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            fin_valid_reg <= fin_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_ready && fin_valid) begin
            fin_reg <= fin_data;
        end
        if (fin_move) begin
            out_reg.addr_ok   <= fin_reg.ok;
            out_reg.addr_high <= expanded[127:64];
            out_reg.addr_low  <= expanded[63:0];
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

endmodule

@@ hw/rtl/ipv6_text_address_parser_unit.sv @@
// IPv6 text address parser: one character per transaction in, one address per text out.
// Latency: after its last character, a result passes the input register, the finished-text
// register and the result register. Throughput: one character per cycle; a last one waits for room.
// Stages: input register, parse state update, finished-text register, gap expansion into the result register.
// Reset (aresetn low, synchronous) empties all stages and returns the parser to leading space.
module ipv6_text_address_parser_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ipv6p_pkg::in_item_t  s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ipv6p_pkg::out_item_t m_item
);
    import ipv6p_pkg::*;

    logic     in_valid_reg, in_valid_next;
    in_item_t in_item_reg;
    logic     core_take;
    logic     fin_valid;
    logic     fin_ready;
    fin_t     fin_data;

    assign s_ready = !in_valid_reg || core_take;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_item;
        end
    end

    ipv6p_parse_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid_reg),
        .in_item   (in_item_reg),
        .in_take   (core_take),
        .fin_valid (fin_valid),
        .fin_ready (fin_ready),
        .fin_data  (fin_data)
    );

    ipv6p_gap_expand u_expand (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fin_valid (fin_valid),
        .fin_ready (fin_ready),
        .fin_data  (fin_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

@@ hw/rtl/ipv6p_checker.sv @@
// Port-level checks for ipv6_text_address_parser_unit, attached by the bind below.
// Depends on ipv6p_pkg and on the top level's port names.
module ipv6p_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input ipv6p_pkg::in_item_t  s_item,
    input logic                 m_valid,
    input logic                 m_ready,
    input ipv6p_pkg::out_item_t m_item
);
    import ipv6p_pkg::*;

    // A stalled input transaction keeps its valid and its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_item))
        else $error("input changed while stalled");

    // A stalled result transaction keeps its valid and its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    // An invalid address always comes out as all zeros.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.addr_ok |-> (m_item.addr_high == 64'd0) && (m_item.addr_low == 64'd0))
        else $error("invalid address carries nonzero bits");

    // Reset empties the result register.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // After its last character is accepted, a result still passes the input, finished-text
    // and result registers, so m_valid cannot rise straight out of reset.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(!aresetn, 1) && !$past(!aresetn, 2))
        else $error("result appeared too soon after reset");

endmodule

bind ipv6_text_address_parser_unit ipv6p_checker u_ipv6p_checker (.*);
